### sv/tcw_pkg.sv
package tcw_pkg;

   // screen geometry
   localparam int ROWS      = 25;
   localparam int COLS      = 80;
   localparam int TAB_WIDTH = 8;
   localparam int CELLS     = ROWS * COLS;

   // field widths
   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int CELL_W = $clog2(CELLS);
   localparam int TAB_W  = (TAB_WIDTH > 2) ? $clog2(TAB_WIDTH) : 1;

   // character codes
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic [7:0]  ATTR_RESET  = 8'h0F;
   localparam logic [15:0] BLANK_RESET = {ATTR_RESET, CH_SPACE};

   // item kinds
   localparam logic KIND_PUT  = 1'b0;
   localparam logic KIND_READ = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_BLANK_EOL,
      ST_TAB,
      ST_SCROLL,
      ST_READ,
      ST_DONE
   } tcw_state_type;

   typedef struct packed {
      logic              we;
      logic [CELL_W-1:0] waddr;
      logic [15:0]       wdata;
      logic              re;
      logic [CELL_W-1:0] raddr;
   } tcw_ram_req_type;

   typedef struct packed {
      logic [15:0]      cell_data;
      logic [ROW_W-1:0] cursor_row;
      logic [COL_W-1:0] cursor_col;
      logic             scrolled;
   } tcw_result_type;

   // linear cell index of a visible row and column under the ring offset
   function automatic logic [CELL_W-1:0] cell_addr(input logic [ROW_W-1:0] top,
                                                    input logic [ROW_W-1:0] vis,
                                                    input logic [COL_W-1:0] col);
      logic [ROW_W:0]   sum;
      logic [ROW_W-1:0] phys;
      sum = {1'b0, top} + {1'b0, vis};
      if (sum >= (ROW_W+1)'(ROWS)) begin
         phys = ROW_W'(sum - (ROW_W+1)'(ROWS));
      end else begin
         phys = sum[ROW_W-1:0];
      end
      return CELL_W'(phys * COLS) + CELL_W'(col);
   endfunction

endpackage

### sv/tcw_ram.sv
module tcw_ram
   import tcw_pkg::*;
(
   input  logic            clock,
   input  tcw_ram_req_type ram_req,
   output logic [15:0]     ram_rdata
);

   logic [15:0] mem [CELLS];
   logic [15:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem[ram_req.waddr] <= ram_req.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_req.re) begin
         rdata_ff <= mem[ram_req.raddr];
      end
   end

   assign ram_rdata = rdata_ff;

endmodule

### sv/tcw_seq.sv
module tcw_seq
   import tcw_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            item_valid,
   output logic            item_ready,
   input  logic            item_kind,
   input  logic [7:0]      item_char,
   input  logic [ROW_W-1:0] item_row,
   input  logic [COL_W-1:0] item_col,
   input  logic [7:0]      attr,
   input  logic            out_free,
   output logic            res_valid,
   output tcw_result_type  res,
   output tcw_ram_req_type ram_req,
   input  logic [15:0]     ram_rdata
);

   tcw_state_type state_ff, state_in;

   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [TAB_W-1:0]  phase_ff, phase_in;
   logic [ROW_W-1:0]  top_ff, top_in;
   logic [COL_W-1:0]  ptr_ff, ptr_in;
   logic [CELL_W-1:0] clr_ff, clr_in;
   logic              scrolled_ff, scrolled_in;
   logic [15:0]       data_ff, data_in;

   logic [15:0]      blank;
   logic             accept;
   logic             at_bottom;
   logic             ptr_last;
   logic             in_range;
   logic             eol_print;
   logic [ROW_W-1:0] top_next;
   logic [TAB_W-1:0] phase_up;
   logic [TAB_W-1:0] phase_down;

   assign blank      = {attr, CH_SPACE};
   assign item_ready = (state_ff == ST_IDLE);
   assign accept     = item_valid && item_ready;
   assign at_bottom  = (row_ff == ROW_W'(ROWS - 1));
   assign ptr_last   = (ptr_ff == COL_W'(COLS - 1));
   assign in_range   = (item_row < ROW_W'(ROWS)) && (item_col < COL_W'(COLS));
   assign eol_print  = ((col_ff + 1'b1) >= COL_W'(COLS - 1));
   assign top_next   = (top_ff == ROW_W'(ROWS - 1)) ? '0 : top_ff + 1'b1;
   assign phase_up   = (phase_ff == TAB_W'(TAB_WIDTH - 1)) ? '0 : phase_ff + 1'b1;
   assign phase_down = (phase_ff == '0) ? TAB_W'(TAB_WIDTH - 1) : phase_ff - 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == CELL_W'(CELLS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (item_kind == KIND_READ) begin
                  state_in = in_range ? ST_READ : ST_DONE;
               end else if (item_char == CH_NL) begin
                  state_in = ST_BLANK_EOL;
               end else if (item_char == CH_TAB) begin
                  state_in = (col_ff >= COL_W'(COLS - TAB_WIDTH)) ? ST_BLANK_EOL : ST_TAB;
               end else if (item_char >= CH_SPACE && eol_print && at_bottom) begin
                  state_in = ST_SCROLL;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_BLANK_EOL: begin
            if (ptr_last) state_in = at_bottom ? ST_SCROLL : ST_DONE;
         end
         ST_TAB: begin
            if (phase_up == '0) state_in = ST_DONE;
         end
         ST_SCROLL: begin
            if (ptr_last) state_in = ST_DONE;
         end
         ST_READ: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // datapath and memory requests
   always_comb begin
      row_in      = row_ff;
      col_in      = col_ff;
      phase_in    = phase_ff;
      top_in      = top_ff;
      ptr_in      = ptr_ff;
      clr_in      = clr_ff;
      scrolled_in = scrolled_ff;
      data_in     = data_ff;
      ram_req     = '0;
      case (state_ff)
         ST_CLEAR: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = clr_ff;
            ram_req.wdata = BLANK_RESET;
            clr_in        = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (accept) begin
               data_in     = '0;
               scrolled_in = 1'b0;
               ptr_in      = col_ff;
               if (item_kind == KIND_READ) begin
                  ram_req.re    = in_range;
                  ram_req.raddr = cell_addr(top_ff, item_row, item_col);
               end else if (item_char == CH_BS) begin
                  if (col_ff != '0) begin
                     ram_req.we    = 1'b1;
                     ram_req.waddr = cell_addr(top_ff, row_ff, col_ff);
                     ram_req.wdata = blank;
                     col_in        = col_ff - 1'b1;
                     phase_in      = phase_down;
                  end
               end else if (item_char >= CH_SPACE) begin
                  ram_req.we    = 1'b1;
                  ram_req.waddr = cell_addr(top_ff, row_ff, col_ff);
                  ram_req.wdata = {attr, item_char};
                  col_in        = col_ff + 1'b1;
                  phase_in      = phase_up;
                  if (eol_print) begin
                     col_in   = '0;
                     phase_in = '0;
                     ptr_in   = '0;
                     if (at_bottom) begin
                        top_in      = top_next;
                        scrolled_in = 1'b1;
                     end else begin
                        row_in = row_ff + 1'b1;
                     end
                  end
               end
            end
         end
         ST_BLANK_EOL: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = cell_addr(top_ff, row_ff, ptr_ff);
            ram_req.wdata = blank;
            ptr_in        = ptr_ff + 1'b1;
            if (ptr_last) begin
               col_in   = '0;
               phase_in = '0;
               ptr_in   = '0;
               if (at_bottom) begin
                  top_in      = top_next;
                  scrolled_in = 1'b1;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end
         end
         ST_TAB: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = cell_addr(top_ff, row_ff, col_ff);
            ram_req.wdata = blank;
            col_in        = col_ff + 1'b1;
            phase_in      = phase_up;
         end
         ST_SCROLL: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = cell_addr(top_ff, row_ff, ptr_ff);
            ram_req.wdata = blank;
            ptr_in        = ptr_ff + 1'b1;
         end
         ST_READ: begin
            data_in = ram_rdata;
         end
         default: begin
         end
      endcase
   end

   assign res_valid      = (state_ff == ST_DONE);
   assign res.cell_data  = data_ff;
   assign res.cursor_row = row_ff;
   assign res.cursor_col = col_ff;
   assign res.scrolled   = scrolled_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         row_ff      <= '0;
         col_ff      <= '0;
         phase_ff    <= '0;
         top_ff      <= '0;
         clr_ff      <= '0;
         scrolled_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         phase_ff    <= phase_in;
         top_ff      <= top_in;
         clr_ff      <= clr_in;
         scrolled_ff <= scrolled_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff  <= ptr_in;
      data_ff <= data_in;
   end

endmodule

### sv/text_console_writer.sv
// Text console writer: keeps a 25 x 80 screen of 16-bit cells (character in the
// low byte, attribute in the high byte) in one single-port-write, registered-read
// memory, with a cursor and a scroll ring offset. A put transaction prints a byte
// at the cursor (backspace, tab and newline handled, other control bytes ignored,
// wrap one column before the right edge, scroll below the last row); a read
// transaction returns one visible cell. Every request gives exactly one response
// carrying the cursor position afterwards. After reset the memory is swept to
// blanks, one cell a cycle, and the request side stays not-ready until the sweep ends.
// A tab blanks cells up to the next tab stop (or, near the line end, acts as a
// newline), a newline blanks the rest of the line, and a scroll blanks the new
// bottom row, one cell write at a time through the single memory write port.
// A new request is taken as soon as the previous response has moved into the
// output register, even if that response is not yet taken downstream.
module text_console_writer
   import tcw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13], zero pad
   input  logic        req_tuser,   // kind: 0 put, 1 read
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // cell_data[15:0], cursor_row[20:16], cursor_col[27:21],
                                    // scrolled[28], zero pad
   // attribute register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   logic [7:0]      attr_ff, attr_in;
   logic            rsp_valid_ff, rsp_valid_in;
   tcw_result_type  rsp_ff, rsp_in;

   logic            out_free;
   logic            res_valid;
   tcw_result_type  res;
   tcw_ram_req_type ram_req;
   logic [15:0]     ram_rdata;

   // attribute register, always writable
   assign csr_ready = 1'b1;
   assign attr_in   = (csr_valid && csr_ready) ? csr_data : attr_ff;

   // output register frees up when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_free) begin
         rsp_valid_in = res_valid;
         if (res_valid) rsp_in = res;
      end
   end

   tcw_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_tvalid),
      .item_ready (req_tready),
      .item_kind  (req_tuser),
      .item_char  (req_tdata[7:0]),
      .item_row   (req_tdata[12:8]),
      .item_col   (req_tdata[19:13]),
      .attr       (attr_ff),
      .out_free   (out_free),
      .res_valid  (res_valid),
      .res        (res),
      .ram_req    (ram_req),
      .ram_rdata  (ram_rdata)
   );

   tcw_ram u_ram (
      .clock     (clock),
      .ram_req   (ram_req),
      .ram_rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff      <= ATTR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         attr_ff      <= attr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_ff.scrolled, rsp_ff.cursor_col,
                        rsp_ff.cursor_row, rsp_ff.cell_data};

endmodule
